FILE: design/xmodem_checksum_receiver_macros.svh
// Assertion macros for the XMODEM checksum receiver.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef XMODEM_CHECKSUM_RECEIVER_MACROS_SVH
`define XMODEM_CHECKSUM_RECEIVER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while in reset
`define XCR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("xcr assertion failed");
// Next-cycle implication, disabled while in reset
`define XCR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("xcr assertion failed");
`else
`define XCR_ASSERT_IMP(lbl, ante, cons)
`define XCR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: design/xcr_pkg.sv
// Shared types and constants for the XMODEM checksum receiver.
// No dependencies; imported by every module of the block.
package xcr_pkg;

    // Sizes; both must be powers of two
    localparam int PAYLOAD_BYTES = 128;
    localparam int MEMORY_BYTES  = 1024;
    localparam int PL_AW         = $clog2(PAYLOAD_BYTES);
    localparam int MEM_AW        = $clog2(MEMORY_BYTES);
    localparam int ROWS          = MEMORY_BYTES / PAYLOAD_BYTES;
    localparam int ROW_W         = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W         = $clog2(PAYLOAD_BYTES + 3);
    localparam int CNT_W         = PL_AW + 1;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    // Line control characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;

    // Transfer status codes
    localparam logic [2:0] STAT_IDLE      = 3'd0;
    localparam logic [2:0] STAT_RUNNING   = 3'd1;
    localparam logic [2:0] STAT_COMPLETED = 3'd2;
    localparam logic [2:0] STAT_CANCELLED = 3'd3;
    localparam logic [2:0] STAT_BAD_CMD   = 3'd4;
    localparam logic [2:0] STAT_TIMEOUTS  = 3'd5;

    // Block event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_ACCEPTED = 3'd1;
    localparam logic [2:0] EV_DUP      = 3'd2;
    localparam logic [2:0] EV_BAD_SEQ  = 3'd3;
    localparam logic [2:0] EV_BAD_COMP = 3'd4;
    localparam logic [2:0] EV_BAD_SUM  = 3'd5;
    localparam logic [2:0] EV_TIMEOUT  = 3'd6;

    // Configuration registers
    localparam int         APB_AW           = 2;
    localparam logic [1:0] REG_MAX_TIMEOUTS = 2'd0;
    localparam logic [7:0] MAX_TIMEOUTS_RST = 8'd10;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
        logic [9:0] read_address;
    } in_item_t;

    typedef struct packed {
        logic       response_valid;
        logic [7:0] response_byte;
        logic [2:0] status;
        logic [2:0] block_event;
        logic [7:0] read_data;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_START   = 2'd2,
        OP_READ    = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        BC_SOH   = 2'd0,
        BC_EOT   = 2'd1,
        BC_CAN   = 2'd2,
        BC_OTHER = 2'd3
    } byte_cls_t;

    // Classified command passed from front to back
    typedef struct packed {
        op_kind_t   kind;
        byte_cls_t  cls;
        logic [7:0] rx_byte;
        logic [9:0] read_address;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic copying;
        logic popping;
    } bk_stat_t;

endpackage

FILE: design/xcr_front.sv
// Front end: accepts input transactions and classifies them into commands.
// Depends on xcr_pkg; feeds xcr_fifo.
module xcr_front import xcr_pkg::*; (
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    input  fifo_stat_t fstat,
    output logic       push,
    output cmd_t       cmd
);

    // Accept whenever the queue has room
    assign s_ready = !fstat.full;
    assign push    = s_valid && !fstat.full;

    // Decode operation and class of the received byte
    always_comb begin
        cmd.kind         = op_kind_t'(s_data.operation);
        cmd.rx_byte      = s_data.rx_byte;
        cmd.read_address = s_data.read_address;
        case (s_data.rx_byte)
            CH_SOH:  cmd.cls = BC_SOH;
            CH_EOT:  cmd.cls = BC_EOT;
            CH_CAN:  cmd.cls = BC_CAN;
            default: cmd.cls = BC_OTHER;
        endcase
    end

endmodule

FILE: design/xcr_fifo.sv
// Short command queue between the front end and the back end.
// Depends on xcr_pkg.
module xcr_fifo import xcr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cmd_t       wr_data,
    input  logic       pop,
    output cmd_t       rd_data,
    output fifo_stat_t stat
);

    cmd_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign stat.full  = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = slot_reg[rptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wptr_next  = do_push ? FIFO_AW'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next  = do_pop  ? FIFO_AW'(rptr_reg + 1'b1) : rptr_reg;
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/xcr_back.sv
// Back end: protocol state machine, payload buffer, target memory and block copy.
// Depends on xcr_pkg; takes commands from xcr_fifo and drives the result register.
module xcr_back import xcr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] max_timeouts,
    input  cmd_t       cmd,
    input  fifo_stat_t fstat,
    output logic       pop,
    output bk_stat_t   stat,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_CMD   = 3'b010,
        PH_BLOCK = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        BK_EXEC = 3'b001,
        BK_READ = 3'b010,
        BK_COPY = 3'b100
    } bk_state_t;

    localparam logic [POS_W-1:0] POS_SUM = POS_W'(PAYLOAD_BYTES + 2);

    bk_state_t         state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        prev_seq_reg, prev_seq_next;
    logic [7:0]        cur_seq_reg, cur_seq_next;
    logic [7:0]        comp_reg, comp_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        tmo_cnt_reg, tmo_cnt_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;
    logic [CNT_W-1:0]  copy_cnt_reg, copy_cnt_next;
    logic [MEM_AW-1:0] copy_addr_reg, copy_addr_next;
    logic [ROW_W-1:0]  copy_row_reg, copy_row_next;
    logic [ROWS-1:0]   row_valid_reg, row_valid_next;
    logic              rd_hit_reg, rd_hit_next;
    logic              rd_inrange_reg, rd_inrange_next;

    logic [7:0]        pbuf_mem [PAYLOAD_BYTES];
    logic [7:0]        tmem_mem [MEMORY_BYTES];
    logic [7:0]        pbuf_q;
    logic [7:0]        tmem_q;
    logic              pbuf_we, pbuf_re, tmem_we, tmem_re;
    logic [PL_AW-1:0]  pbuf_waddr;

    logic              slot_free;
    logic [MEM_AW-1:0] rd_addr;
    logic [ROW_W-1:0]  rd_row;
    logic              rd_inrange;
    logic [7:0]        tmo_inc;
    logic [7:0]        seq_m1;
    logic              row_inrange;
    logic [2:0]        judge_ev;
    logic              produce;
    out_item_t         res;

    assign slot_free   = !out_valid_reg || m_ready;
    assign rd_addr     = MEM_AW'(cmd.read_address);
    assign rd_row      = ROW_W'(rd_addr >> PL_AW);
    assign rd_inrange  = 32'(cmd.read_address) < 32'(MEMORY_BYTES);
    assign tmo_inc     = tmo_cnt_reg + 8'd1;
    assign seq_m1      = cur_seq_reg - 8'd1;
    assign row_inrange = 32'(seq_m1) < 32'(ROWS);
    assign pbuf_waddr  = PL_AW'(pos_reg - POS_W'(2));

    assign m_valid      = out_valid_reg;
    assign m_data       = out_reg;
    assign stat.copying = (state_reg == BK_COPY);
    assign stat.popping = pop;

    // Judge a finished block in protocol order
    always_comb begin
        if (cur_seq_reg == prev_seq_reg) begin
            judge_ev = EV_DUP;
        end else if ({1'b0, cur_seq_reg} != {1'b0, prev_seq_reg} + 9'd1) begin
            judge_ev = EV_BAD_SEQ;
        end else if (comp_reg != ~cur_seq_reg) begin
            judge_ev = EV_BAD_COMP;
        end else if (sum_reg != cmd.rx_byte) begin
            judge_ev = EV_BAD_SUM;
        end else begin
            judge_ev = EV_ACCEPTED;
        end
    end

    // Execute one command, finish a read, or sweep a block into memory
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        prev_seq_next   = prev_seq_reg;
        cur_seq_next    = cur_seq_reg;
        comp_next       = comp_reg;
        sum_next        = sum_reg;
        tmo_cnt_next    = tmo_cnt_reg;
        copy_cnt_next   = copy_cnt_reg;
        copy_addr_next  = copy_addr_reg;
        copy_row_next   = copy_row_reg;
        row_valid_next  = row_valid_reg;
        rd_hit_next     = rd_hit_reg;
        rd_inrange_next = rd_inrange_reg;
        pop             = 1'b0;
        pbuf_we         = 1'b0;
        pbuf_re         = 1'b0;
        tmem_we         = 1'b0;
        tmem_re         = 1'b0;
        produce         = 1'b0;
        res             = '0;

        case (state_reg)
            BK_EXEC: begin
                if (!fstat.empty && slot_free) begin
                    pop = 1'b1;
                    case (cmd.kind)
                        OP_READ: begin
                            tmem_re         = 1'b1;
                            rd_inrange_next = rd_inrange;
                            rd_hit_next     = row_valid_reg[rd_row];
                            state_next      = BK_READ;
                        end
                        OP_START: begin
                            phase_next         = PH_CMD;
                            prev_seq_next      = '0;
                            tmo_cnt_next       = '0;
                            pos_next           = '0;
                            produce            = 1'b1;
                            res.response_valid = 1'b1;
                            res.response_byte  = CH_NAK;
                            res.status         = STAT_RUNNING;
                        end
                        OP_TIMEOUT: begin
                            produce = 1'b1;
                            if (phase_reg == PH_BLOCK) begin
                                phase_next         = PH_CMD;
                                tmo_cnt_next       = '0;
                                res.response_valid = 1'b1;
                                res.response_byte  = CH_NAK;
                                res.status         = STAT_RUNNING;
                                res.block_event    = EV_TIMEOUT;
                            end else if (phase_reg == PH_CMD) begin
                                tmo_cnt_next = tmo_inc;
                                if (tmo_inc >= max_timeouts) begin
                                    phase_next = PH_IDLE;
                                    res.status = STAT_TIMEOUTS;
                                end else begin
                                    res.response_valid = 1'b1;
                                    res.response_byte  = CH_NAK;
                                    res.status         = STAT_RUNNING;
                                end
                            end
                        end
                        OP_BYTE: begin
                            produce = 1'b1;
                            if (phase_reg == PH_CMD) begin
                                tmo_cnt_next = '0;
                                case (cmd.cls)
                                    BC_CAN: begin
                                        phase_next = PH_IDLE;
                                        res.status = STAT_CANCELLED;
                                    end
                                    BC_EOT: begin
                                        phase_next         = PH_IDLE;
                                        res.response_valid = 1'b1;
                                        res.response_byte  = CH_ACK;
                                        res.status         = STAT_COMPLETED;
                                    end
                                    BC_SOH: begin
                                        phase_next = PH_BLOCK;
                                        pos_next   = '0;
                                        sum_next   = '0;
                                        res.status = STAT_RUNNING;
                                    end
                                    default: begin
                                        phase_next         = PH_IDLE;
                                        res.response_valid = 1'b1;
                                        res.response_byte  = CH_CAN;
                                        res.status         = STAT_BAD_CMD;
                                    end
                                endcase
                            end else if (phase_reg == PH_BLOCK) begin
                                res.status = STAT_RUNNING;
                                if (pos_reg == POS_SUM) begin
                                    // Block complete: answer, and start the copy if good and its row lies in memory
                                    phase_next         = PH_CMD;
                                    pos_next           = '0;
                                    tmo_cnt_next       = '0;
                                    res.block_event    = judge_ev;
                                    res.response_valid = 1'b1;
                                    if (judge_ev == EV_ACCEPTED) begin
                                        res.response_byte = CH_ACK;
                                        prev_seq_next     = cur_seq_reg;
                                        if (row_inrange) begin
                                            state_next     = BK_COPY;
                                            copy_cnt_next  = '0;
                                            copy_row_next  = ROW_W'(seq_m1);
                                            copy_addr_next = MEM_AW'(32'(seq_m1) << PL_AW);
                                        end
                                    end else if (judge_ev == EV_DUP) begin
                                        res.response_byte = CH_ACK;
                                    end else begin
                                        res.response_byte = CH_NAK;
                                    end
                                end else begin
                                    pos_next = pos_reg + 1'b1;
                                    if (pos_reg == '0) begin
                                        cur_seq_next = cmd.rx_byte;
                                    end else if (pos_reg == POS_W'(1)) begin
                                        comp_next = cmd.rx_byte;
                                    end else begin
                                        pbuf_we  = 1'b1;
                                        sum_next = sum_reg + cmd.rx_byte;
                                    end
                                end
                            end
                        end
                        default: begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ: begin
                // Hold until the result slot frees; memory output stays put
                if (slot_free) begin
                    produce    = 1'b1;
                    state_next = BK_EXEC;
                    res.status = (phase_reg != PH_IDLE) ? STAT_RUNNING : STAT_IDLE;
                    if (rd_inrange_reg) begin
                        res.read_data = rd_hit_reg ? tmem_q : 8'hFF;
                    end
                end
            end
            BK_COPY: begin
                // Read buffer entry n while writing entry n-1 to memory
                if (copy_cnt_reg < CNT_W'(PAYLOAD_BYTES)) begin
                    pbuf_re = 1'b1;
                end
                if (copy_cnt_reg != '0) begin
                    tmem_we        = 1'b1;
                    copy_addr_next = copy_addr_reg + 1'b1;
                end
                if (copy_cnt_reg == CNT_W'(PAYLOAD_BYTES)) begin
                    row_valid_next[copy_row_reg] = 1'b1;
                    state_next                   = BK_EXEC;
                end else begin
                    copy_cnt_next = copy_cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = BK_EXEC;
            end
        endcase

        // Load or drain the result register
        if (produce) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end else begin
            out_valid_next = out_valid_reg && !m_ready;
            out_next       = out_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_EXEC;
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            prev_seq_reg  <= '0;
            cur_seq_reg   <= '0;
            comp_reg      <= '0;
            sum_reg       <= '0;
            tmo_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            copy_cnt_reg  <= '0;
            copy_addr_reg <= '0;
            copy_row_reg  <= '0;
            row_valid_reg <= '0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            prev_seq_reg  <= prev_seq_next;
            cur_seq_reg   <= cur_seq_next;
            comp_reg      <= comp_next;
            sum_reg       <= sum_next;
            tmo_cnt_reg   <= tmo_cnt_next;
            out_valid_reg <= out_valid_next;
            copy_cnt_reg  <= copy_cnt_next;
            copy_addr_reg <= copy_addr_next;
            copy_row_reg  <= copy_row_next;
            row_valid_reg <= row_valid_next;
        end
    end

    // Result payload and read flags carry no reset
    always_ff @(posedge aclk) begin
        out_reg        <= out_next;
        rd_hit_reg     <= rd_hit_next;
        rd_inrange_reg <= rd_inrange_next;
    end

    // Payload buffer: written per byte, read during the copy
    always_ff @(posedge aclk) begin
        if (pbuf_we) begin
            pbuf_mem[pbuf_waddr] <= cmd.rx_byte;
        end
        if (pbuf_re) begin
            pbuf_q <= pbuf_mem[copy_cnt_reg[PL_AW-1:0]];
        end
    end

    // Target memory: written by the copy, read by read commands
    always_ff @(posedge aclk) begin
        if (tmem_we) begin
            tmem_mem[copy_addr_reg] <= pbuf_q;
        end
        if (tmem_re) begin
            tmem_q <= tmem_mem[rd_addr];
        end
    end

endmodule

FILE: design/xmodem_checksum_receiver.sv
// XMODEM checksum receiver top level: APB register, front end, queue, back end.
// Each result passes the command queue and the result register; a read also waits for
// the registered memory read. Throughput: one transaction per cycle while results drain;
// a read holds the back end until its data is out, and a good block holds it after its
// ACK while the buffer is copied to memory. Reset: synchronous, clears control state;
// memory rows read as 0xFF via per-row valid bits; no clearing pass. Depends on xcr_pkg.
`include "xmodem_checksum_receiver_macros.svh"
module xmodem_checksum_receiver import xcr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] max_timeouts_reg, max_timeouts_next;
    logic       cfg_wr;
    logic       push, pop;
    cmd_t       front_cmd, queue_cmd;
    fifo_stat_t fstat;
    bk_stat_t   bstat;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        max_timeouts_next = max_timeouts_reg;
        if (cfg_wr && (paddr == REG_MAX_TIMEOUTS)) begin
            max_timeouts_next = pwdata[7:0];
        end
        prdata = '0;
        if (paddr == REG_MAX_TIMEOUTS) begin
            prdata = {24'b0, max_timeouts_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_timeouts_reg <= MAX_TIMEOUTS_RST;
        end else begin
            max_timeouts_reg <= max_timeouts_next;
        end
    end

    xcr_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .fstat   (fstat),
        .push    (push),
        .cmd     (front_cmd)
    );

    xcr_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (front_cmd),
        .pop     (pop),
        .rd_data (queue_cmd),
        .stat    (fstat)
    );

    xcr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .max_timeouts (max_timeouts_reg),
        .cmd          (queue_cmd),
        .fstat        (fstat),
        .pop          (pop),
        .stat         (bstat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    // A sent response is always one of the three control characters
    `XCR_ASSERT_IMP(a_resp_code, m_valid && m_data.response_valid,
        m_data.response_byte == CH_ACK || m_data.response_byte == CH_NAK ||
        m_data.response_byte == CH_CAN)
    // No response means a zero response byte
    `XCR_ASSERT_IMP(a_no_resp_zero, m_valid && !m_data.response_valid, m_data.response_byte == 8'h00)
    // The queue is not drained while a block is copied
    `XCR_ASSERT_IMP(a_copy_no_pop, bstat.copying, !bstat.popping)
    // A copy starts only behind an accepted block result
    `XCR_ASSERT_IMP(a_copy_after_ack, $rose(bstat.copying),
        m_valid && m_data.block_event == EV_ACCEPTED)
    // A copy is still running in the cycle after it starts
    `XCR_ASSERT_NXT(a_copy_span, $rose(bstat.copying), bstat.copying)

endmodule

FILE: test/xcr_response_checker.sv
// Response checker for the XMODEM checksum receiver: tracks every transaction on both
// channels and the APB register, predicts each response and compares it field by field.
// Depends on xcr_pkg for the payload types, opcodes, status and event codes.
module xcr_response_checker import xcr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_item_t          s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                mismatches,
    output int                pending
);

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_COMMAND,
        RX_BLOCK
    } rx_phase_t;

    // Receiver state as the protocol sees it
    rx_phase_t   phase_q;
    int unsigned byte_pos;
    logic [7:0]  last_seq;
    logic [7:0]  blk_seq;
    logic [7:0]  blk_comp;
    logic [7:0]  blk_sum;
    logic [7:0]  timeouts_seen;
    logic [7:0]  timeout_limit;
    logic [7:0]  payload [PAYLOAD_BYTES];
    logic [7:0]  image [MEMORY_BYTES];

    out_item_t   due_responses [$];
    out_item_t   want;
    int          k;

    function automatic out_item_t pack_response(logic [7:0] resp, logic [2:0] st,
                                                logic [2:0] ev, logic [7:0] rd);
        out_item_t r;
        r.response_valid = (resp != 8'h00);
        r.response_byte  = resp;
        r.status         = st;
        r.block_event    = ev;
        r.read_data      = rd;
        return r;
    endfunction

    // Advance the protocol state by one transaction and return the response it causes
    function automatic out_item_t next_response(in_item_t it);
        op_kind_t   op;
        logic [2:0] run_st;
        logic [2:0] ev;
        logic [7:0] b;
        int         base;
        int         i;
        op     = op_kind_t'(it.operation);
        b      = it.rx_byte;
        run_st = (phase_q != RX_IDLE) ? STAT_RUNNING : STAT_IDLE;

        if (op == OP_READ)
            return pack_response(8'h00, run_st, EV_NONE, image[it.read_address]);

        // A start always (re)opens the transfer
        if (op == OP_START) begin
            phase_q       = RX_COMMAND;
            last_seq      = 8'h00;
            timeouts_seen = 8'h00;
            byte_pos      = 0;
            return pack_response(CH_NAK, STAT_RUNNING, EV_NONE, 8'h00);
        end

        // Bytes and timeouts with no transfer running are dropped
        if (phase_q == RX_IDLE)
            return pack_response(8'h00, STAT_IDLE, EV_NONE, 8'h00);

        if (op == OP_TIMEOUT) begin
            if (phase_q == RX_BLOCK) begin
                phase_q       = RX_COMMAND;
                timeouts_seen = 8'h00;
                return pack_response(CH_NAK, STAT_RUNNING, EV_TIMEOUT, 8'h00);
            end
            timeouts_seen = timeouts_seen + 8'd1;
            if (timeouts_seen >= timeout_limit) begin
                phase_q = RX_IDLE;
                return pack_response(8'h00, STAT_TIMEOUTS, EV_NONE, 8'h00);
            end
            return pack_response(CH_NAK, STAT_RUNNING, EV_NONE, 8'h00);
        end

        // Command byte
        if (phase_q == RX_COMMAND) begin
            timeouts_seen = 8'h00;
            case (b)
                CH_CAN: begin
                    phase_q = RX_IDLE;
                    return pack_response(8'h00, STAT_CANCELLED, EV_NONE, 8'h00);
                end
                CH_EOT: begin
                    phase_q = RX_IDLE;
                    return pack_response(CH_ACK, STAT_COMPLETED, EV_NONE, 8'h00);
                end
                CH_SOH: begin
                    phase_q  = RX_BLOCK;
                    byte_pos = 0;
                    blk_sum  = 8'h00;
                    return pack_response(8'h00, STAT_RUNNING, EV_NONE, 8'h00);
                end
                default: begin
                    phase_q = RX_IDLE;
                    return pack_response(CH_CAN, STAT_BAD_CMD, EV_NONE, 8'h00);
                end
            endcase
        end

        // Block byte: header, payload, then the sum that closes the block
        if (byte_pos == 0) begin
            blk_seq = b;
        end else if (byte_pos == 1) begin
            blk_comp = b;
        end else if (byte_pos < PAYLOAD_BYTES + 2) begin
            payload[byte_pos - 2] = b;
            blk_sum = blk_sum + b;
        end else begin
            if (blk_seq == last_seq)
                ev = EV_DUP;
            else if ({1'b0, blk_seq} != {1'b0, last_seq} + 9'd1)
                ev = EV_BAD_SEQ;
            else if (blk_comp != 8'hFF - blk_seq)
                ev = EV_BAD_COMP;
            else if (blk_sum != b)
                ev = EV_BAD_SUM;
            else
                ev = EV_ACCEPTED;
            phase_q       = RX_COMMAND;
            byte_pos      = 0;
            timeouts_seen = 8'h00;
            if (ev == EV_ACCEPTED) begin
                // Copy into the image; rows past the end are dropped
                base = (int'(blk_seq) - 1) * PAYLOAD_BYTES;
                for (i = 0; i < PAYLOAD_BYTES; i++)
                    if (base + i < MEMORY_BYTES)
                        image[base + i] = payload[i];
                last_seq = blk_seq;
                return pack_response(CH_ACK, STAT_RUNNING, EV_ACCEPTED, 8'h00);
            end
            if (ev == EV_DUP)
                return pack_response(CH_ACK, STAT_RUNNING, EV_DUP, 8'h00);
            return pack_response(CH_NAK, STAT_RUNNING, ev, 8'h00);
        end
        byte_pos++;
        return pack_response(8'h00, STAT_RUNNING, EV_NONE, 8'h00);
    endfunction

    task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
        if (act_val !== exp_val) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase_q       = RX_IDLE;
            byte_pos      = 0;
            last_seq      = 8'h00;
            blk_seq       = 8'h00;
            blk_comp      = 8'h00;
            blk_sum       = 8'h00;
            timeouts_seen = 8'h00;
            timeout_limit = MAX_TIMEOUTS_RST;
            for (k = 0; k < MEMORY_BYTES; k++)
                image[k] = 8'hFF;
            due_responses.delete();
            mismatches = 0;
        end else begin
            // Compare the response transaction with the oldest prediction
            if (m_valid && m_ready) begin
                if (due_responses.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected response, expected none, actual %h",
                             $time, m_data);
                end else begin
                    want = due_responses.pop_front();
                    check_field("response_valid", 8'(want.response_valid),
                                8'(m_data.response_valid));
                    check_field("response_byte", want.response_byte, m_data.response_byte);
                    check_field("status", 8'(want.status), 8'(m_data.status));
                    check_field("block_event", 8'(want.block_event), 8'(m_data.block_event));
                    check_field("read_data", want.read_data, m_data.read_data);
                end
            end
            // Predict the response of each accepted input transaction
            if (s_valid && s_ready)
                due_responses.push_back(next_response(s_data));
            // Track register writes
            if (psel && penable && pwrite && pready && paddr == REG_MAX_TIMEOUTS)
                timeout_limit = pwdata[7:0];
        end
        pending = due_responses.size();
    end

endmodule

FILE: test/tb_xmodem_checksum_receiver.sv
// Testbench top for the XMODEM checksum receiver: clock, reset, stimulus and verdict.
// Needs xcr_pkg, the receiver RTL and xcr_response_checker, which does all checking.
module tb_xmodem_checksum_receiver;
    import xcr_pkg::*;

    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_CUT
    } flaw_t;

    typedef enum int {
        BK_GOOD,
        BK_DUP,
        BK_SEQ,
        BK_COMP,
        BK_SUM,
        BK_CUT
    } block_kind_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int         mismatches;
    int         pending;
    int         burst_left;
    int         sent;
    int         hold_asks;
    logic [7:0] max_setting;
    logic [7:0] last_seq;
    int         cmd_timeouts;
    logic       running;
    logic [5:0] kinds_seen;

    xmodem_checksum_receiver dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    xcr_response_checker resp_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stop a hung run
    initial begin
        #48000000;
        $display("tb_xmodem_checksum_receiver NOT OK");
        $finish;
    end

    // Response side: random ready modes, plus one long hold-off on request
    initial begin
        int mode;
        int left;
        int hold_left;
        int hold_seen;
        m_ready   = 1'b0;
        mode      = 0;
        left      = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = 400;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // Offer one input transaction; the sender runs in bursts with gaps between them
    task automatic offer(input op_kind_t op, input logic [7:0] b, input logic [9:0] a);
        in_item_t it;
        int       gap;
        it.operation    = op;
        it.rx_byte      = b;
        it.read_address = a;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        offer(OP_BYTE, b, 10'($urandom));
    endtask

    task automatic send_timeout();
        offer(OP_TIMEOUT, 8'($urandom), 10'($urandom));
    endtask

    task automatic send_start();
        offer(OP_START, 8'($urandom), 10'($urandom));
    endtask

    task automatic send_read(input logic [9:0] a);
        offer(OP_READ, 8'($urandom), a);
    endtask

    // Drop valid and wait until every response is back and the copy has finished
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (PAYLOAD_BYTES + 16) @(posedge aclk);
    endtask

    task automatic set_max_timeouts(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_TIMEOUTS;
        pwdata  <= {24'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        max_setting = v;
    endtask

    // Send SOH, header, payload and sum; a cut block ends in a timeout instead
    task automatic send_block(input logic [7:0] seq, input logic [7:0] comp,
                              input flaw_t flaw);
        logic [7:0] body [PAYLOAD_BYTES];
        logic [7:0] sum;
        int         fill;
        int         cut;
        int         i;
        fill = $urandom_range(0, 9);
        sum  = 8'h00;
        for (i = 0; i < PAYLOAD_BYTES; i++) begin
            body[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
            sum = sum + body[i];
        end
        if (flaw == FLAW_SUM)
            sum = sum + 8'($urandom_range(1, 255));
        cut = (flaw == FLAW_CUT) ? $urandom_range(0, PAYLOAD_BYTES + 2) : -1;
        send_byte(CH_SOH);
        for (i = 0; i < PAYLOAD_BYTES + 3; i++) begin
            if (i == cut) begin
                send_timeout();
                return;
            end
            if ($urandom_range(0, 63) == 0)
                send_read(10'($urandom));
            if (i == 0)
                send_byte(seq);
            else if (i == 1)
                send_byte(comp);
            else if (i < PAYLOAD_BYTES + 2)
                send_byte(body[i - 2]);
            else
                send_byte(sum);
        end
    endtask

    task automatic command_timeout();
        send_timeout();
        cmd_timeouts++;
        if (cmd_timeouts >= max_setting)
            running = 1'b0;
    endtask

    // One transfer: start, a few block attempts or line events, then possibly an ending
    task automatic run_transfer();
        int         steps;
        int         pick;
        int         n;
        logic [7:0] s;
        logic [7:0] c;
        send_start();
        running      = 1'b1;
        last_seq     = 8'h00;
        cmd_timeouts = 0;
        steps = $urandom_range(1, 6);
        repeat (steps) begin
            if (!running)
                break;
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                s = last_seq + 8'd1;
                send_block(s, ~s, FLAW_NONE);
                last_seq = s;
                kinds_seen[BK_GOOD] = 1'b1;
            end else if (pick < 45) begin
                // duplicate wins over every other flaw
                send_block(last_seq, 8'($urandom),
                           $urandom_range(0, 1) ? FLAW_SUM : FLAW_NONE);
                kinds_seen[BK_DUP] = 1'b1;
            end else if (pick < 55) begin
                s = 8'($urandom);
                while (s == last_seq || {1'b0, s} == {1'b0, last_seq} + 9'd1)
                    s = 8'($urandom);
                send_block(s, 8'($urandom), $urandom_range(0, 1) ? FLAW_SUM : FLAW_NONE);
                kinds_seen[BK_SEQ] = 1'b1;
            end else if (pick < 65) begin
                s = last_seq + 8'd1;
                c = ~s ^ 8'($urandom_range(1, 255));
                send_block(s, c, $urandom_range(0, 1) ? FLAW_SUM : FLAW_NONE);
                kinds_seen[BK_COMP] = 1'b1;
            end else if (pick < 75) begin
                s = last_seq + 8'd1;
                send_block(s, ~s, FLAW_SUM);
                kinds_seen[BK_SUM] = 1'b1;
            end else if (pick < 85) begin
                s = ($urandom_range(0, 1) == 0) ? last_seq + 8'd1 : 8'($urandom);
                send_block(s, ~s, FLAW_CUT);
                kinds_seen[BK_CUT] = 1'b1;
            end else if (pick < 93) begin
                n = $urandom_range(1, 2);
                while (n > 0 && running) begin
                    command_timeout();
                    n--;
                end
            end else begin
                repeat ($urandom_range(1, 3)) send_read(10'($urandom));
            end
            if (pick < 85)
                cmd_timeouts = 0;
        end
        if (running) begin
            pick = $urandom_range(0, 4);
            case (pick)
                0: send_byte(CH_EOT);
                1: send_byte(CH_CAN);
                2: begin
                    s = 8'($urandom);
                    while (s == CH_SOH || s == CH_EOT || s == CH_CAN)
                        s = 8'($urandom);
                    send_byte(s);
                end
                3: begin
                    if (max_setting <= 8'd16) begin
                        while (running)
                            command_timeout();
                    end else begin
                        send_byte(CH_EOT);
                    end
                end
                default: ;
            endcase
        end
        running = 1'b0;
    endtask

    initial begin
        int         seq;
        int         phase_no;
        int         phase_base;
        logic [7:0] lim;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        burst_left   = 0;
        sent         = 0;
        hold_asks    = 0;
        max_setting  = MAX_TIMEOUTS_RST;
        last_seq     = 8'h00;
        cmd_timeouts = 0;
        running      = 1'b0;
        kinds_seen   = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, idle drops, every command and a block timeout
        send_read(10'd0);
        send_read(10'd1023);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_timeout();
        send_start();
        send_byte(CH_EOT);
        send_start();
        send_byte(CH_CAN);
        send_start();
        send_byte(8'hFF);
        send_start();
        send_start();
        send_timeout();
        send_byte(CH_SOH);
        send_byte(8'h01);
        send_byte(8'hFE);
        send_timeout();
        repeat (MAX_TIMEOUTS_RST) send_timeout();
        settle();

        // Smallest limit: the first command timeout fails
        set_max_timeouts(8'd1);
        send_start();
        send_timeout();
        send_start();
        send_byte(CH_SOH);
        send_timeout();
        send_timeout();
        settle();

        // Largest limit
        set_max_timeouts(8'd255);
        send_start();
        repeat (255) send_timeout();
        settle();

        // Short good-block run under a long receiver stall
        set_max_timeouts(8'($urandom_range(2, 20)));
        hold_asks <= hold_asks + 1;
        send_start();
        for (seq = 1; seq <= 2; seq++)
            send_block(8'(seq), ~8'(seq), FLAW_NONE);
        send_byte(CH_EOT);
        settle();

        // Random transfers over several limit settings
        phase_no = 0;
        while (sent < 800 || kinds_seen != '1) begin
            case (phase_no % 4)
                0: lim = 8'($urandom_range(2, 12));
                1: lim = 8'd1;
                2: lim = 8'd255;
                default: lim = 8'($urandom_range(1, 255));
            endcase
            set_max_timeouts(lim);
            phase_base = sent;
            while (sent - phase_base < 200) begin
                // line noise while no transfer runs
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(0, 2))
                            0: send_byte(8'($urandom));
                            1: send_timeout();
                            default: send_read(10'($urandom));
                        endcase
                    end
                end
                run_transfer();
            end
            settle();
            phase_no++;
        end

        if (mismatches == 0)
            $display("tb_xmodem_checksum_receiver OK");
        else
            $display("tb_xmodem_checksum_receiver NOT OK");
        $finish;
    end

endmodule
